@@ src/tpk_pkg.sv @@
// ============================================================================
// tpk_pkg
// Shared types, constants and helpers of the terrain peak score block.
// ============================================================================
package tpk_pkg;

    // Q0.12 unit and value width
    localparam int          VAL_W = 13;
    localparam logic [12:0] UNIT  = 13'd4096;

    // Base score weights, Q0.12
    localparam logic [10:0] W_ELEV   = 11'd1720;
    localparam logic [10:0] W_CONVEX = 11'd1229;
    localparam logic [10:0] W_MOUNT  = 11'd819;
    localparam logic [10:0] W_SLOPE  = 11'd328;

    // Configuration register indexes
    localparam logic [1:0] CFG_FALLOFF = 2'd0;
    localparam logic [1:0] CFG_PRECISE = 2'd1;
    localparam logic [1:0] CFG_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_HEIGHT  = 2'd3;

    // Control part of one result job
    typedef struct packed {
        logic [1:0] ebank;  // elevation bank of the current input row
        logic       sbank;  // score bank of the current input row
        logic       rel;    // 1: center row is the row above the input row
        logic       top;    // center row is row 0
        logic       bot;    // center row is the last row
        logic       last;   // last result of its input item
    } job_ctrl_t;

    // Signed Q3.12 clamped to 0..1
    function automatic logic [12:0] clamp_unit(input logic [15:0] raw);
        logic [12:0] v;
        if (raw[15])
            v = 13'd0;
        else if (raw > 16'd4096)
            v = UNIT;
        else
            v = raw[12:0];
        return v;
    endfunction

    // Bank holding the row that lies rel rows above the current row
    function automatic logic [1:0] bank_of(input logic [1:0] cur, input logic [1:0] rel);
        logic [2:0] t;
        t = {1'b0, cur} + 3'd3 - {1'b0, rel};
        if (t >= 3'd3)
            t = t - 3'd3;
        return t[1:0];
    endfunction

endpackage

@@ src/tpk_store.sv @@
// ============================================================================
// tpk_store
// Line stores: three elevation rows and two base score rows.
// ============================================================================
module tpk_store
    import tpk_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int CW        = 11
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [1:0]       w_ebank,
    input  logic             w_sbank,
    input  logic [CW-1:0]    w_col,
    input  logic [VAL_W-1:0] w_elev,
    input  logic [VAL_W-1:0] w_score,
    input  logic [1:0]       r_ebank,
    input  logic [CW-1:0]    r_ecol,
    output logic [VAL_W-1:0] r_edata,
    input  logic             r_sbank,
    input  logic [CW-1:0]    r_scol,
    output logic [VAL_W-1:0] r_sdata
);

    localparam int EAW = $clog2(3 * MAX_WIDTH);
    localparam int SAW = $clog2(2 * MAX_WIDTH);

    logic [VAL_W-1:0] elev_mem  [0:3*MAX_WIDTH-1];
    logic [VAL_W-1:0] score_mem [0:2*MAX_WIDTH-1];

    logic [EAW-1:0] ew_addr;
    logic [EAW-1:0] er_addr;
    logic [SAW-1:0] sw_addr;
    logic [SAW-1:0] sr_addr;

    function automatic logic [EAW-1:0] eaddr(input logic [1:0] bank, input logic [CW-1:0] col);
        logic [EAW-1:0] a;
        case (bank)
            2'd0:    a = EAW'(col);
            2'd1:    a = EAW'(col) + EAW'(MAX_WIDTH);
            2'd2:    a = EAW'(col) + EAW'(2 * MAX_WIDTH);
            default: a = EAW'(col);
        endcase
        return a;
    endfunction

    // Address map: bank times row length plus column
    assign ew_addr = eaddr(w_ebank, w_col);
    assign er_addr = eaddr(r_ebank, r_ecol);
    assign sw_addr = w_sbank ? SAW'(w_col) + SAW'(MAX_WIDTH) : SAW'(w_col);
    assign sr_addr = r_sbank ? SAW'(r_scol) + SAW'(MAX_WIDTH) : SAW'(r_scol);

    // Elevation store
    always_ff @(posedge clk)
    begin
        if (we)
            elev_mem[ew_addr] <= w_elev;
        r_edata <= elev_mem[er_addr];
    end

    // Base score store
    always_ff @(posedge clk)
    begin
        if (we)
            score_mem[sw_addr] <= w_score;
        r_sdata <= score_mem[sr_addr];
    end

endmodule

@@ src/tpk_queue.sv @@
// ============================================================================
// tpk_queue
// Four-entry job queue between front end and back end.
// ============================================================================
module tpk_queue
#(
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          empty,
    output logic          full
);

    logic [DW-1:0] slot_reg [0:3];
    logic [1:0]    wr_ptr_reg;
    logic [1:0]    rd_ptr_reg;
    logic [2:0]    count_reg;
    logic [2:0]    count_next;

    assign empty = (count_reg == 3'd0);
    assign full  = (count_reg == 3'd4);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 3'd1;
        else if (pop && !push)
            count_next = count_reg - 3'd1;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

@@ src/tpk_front.sv @@
// ============================================================================
// tpk_front
// Accepts a pixel, forms its base score, writes the line stores and queues
// the result jobs the pixel releases.
// ============================================================================
module tpk_front
    import tpk_pkg::*;
#(
    parameter int CW = 11,
    parameter int WW = 12,
    parameter int RW = 12,
    parameter int HW = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      elevation,
    input  logic [15:0]      convexity,
    input  logic [15:0]      mountain,
    input  logic [15:0]      slope_degrees,
    input  logic [WW-1:0]    w_eff,
    input  logic [HW-1:0]    h_eff,
    input  logic             back_idle,
    input  logic             q_empty,
    output logic             wr_en,
    output logic [1:0]       wr_ebank,
    output logic             wr_sbank,
    output logic [CW-1:0]    wr_col,
    output logic [VAL_W-1:0] wr_elev,
    output logic [VAL_W-1:0] wr_score,
    output logic             q_push,
    output job_ctrl_t        q_ctrl,
    output logic [CW-1:0]    q_cx,
    output logic [RW-1:0]    q_cy
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_S0   = 3'd1;
    localparam logic [2:0] F_S1   = 3'd2;
    localparam logic [2:0] F_S2   = 3'd3;
    localparam logic [2:0] F_S3   = 3'd4;
    localparam logic [2:0] F_WR   = 3'd5;
    localparam logic [2:0] F_JOB  = 3'd6;

    logic [2:0]       state_reg;
    logic [VAL_W-1:0] e_reg, c_reg, m_reg, s_reg;
    logic [20:0]      n_reg;
    logic [14:0]      q0_reg;
    logic [24:0]      acc_reg;
    logic [CW-1:0]    x_reg, col_reg;
    logic [RW-1:0]    y_reg, row_reg;
    logic [1:0]       cur_elev_reg;
    logic             cur_score_reg;
    logic [3:0]       cand_reg;
    logic [1:0]       jn_reg;

    logic [CW-1:0]    x_now, wm1;
    logic [RW-1:0]    y_now, hm1;
    logic             accept;
    logic [3:0]       cand_next;
    logic [20:0]      r65;
    logic [VAL_W-1:0] s_next;
    logic             job_last;

    assign wm1 = CW'(32'(w_eff) - 32'd1);
    assign hm1 = RW'(32'(h_eff) - 32'd1);

    // Counters beyond the current size stand at the last column or row
    assign x_now = (32'(col_reg) >= 32'(w_eff)) ? wm1 : col_reg;
    assign y_now = (32'(row_reg) >= 32'(h_eff)) ? hm1 : row_reg;

    assign in_ready = (state_reg == F_IDLE) && back_idle && q_empty;
    assign accept   = in_valid && in_ready;

    // Slope / 65 with rounding: reciprocal estimate plus one correction
    assign r65    = n_reg - 21'(q0_reg) * 21'd65;
    assign s_next = (n_reg >= 21'd266305) ? UNIT :
                    ((r65 >= 21'd65) ? 13'(q0_reg + 15'd1) : 13'(q0_reg));

    // Results released by this pixel, in emission order
    assign cand_next[0] = (y_reg != '0) && (x_reg != '0);
    assign cand_next[1] = (y_reg != '0) && (x_reg == wm1);
    assign cand_next[2] = (y_reg == hm1) && (x_reg != '0);
    assign cand_next[3] = (y_reg == hm1) && (x_reg == wm1);

    // Line store write
    assign wr_en    = (state_reg == F_WR);
    assign wr_ebank = cur_elev_reg;
    assign wr_sbank = cur_score_reg;
    assign wr_col   = x_reg;
    assign wr_elev  = e_reg;
    assign wr_score = 13'((acc_reg + 25'd2048) >> 12);

    // Job fields for the slot at jn_reg
    always_comb
    begin
        case (jn_reg)
            2'd0:    begin q_cx = x_reg - 1'b1; q_cy = y_reg - 1'b1; end
            2'd1:    begin q_cx = wm1;          q_cy = y_reg - 1'b1; end
            2'd2:    begin q_cx = x_reg - 1'b1; q_cy = y_reg;        end
            default: begin q_cx = wm1;          q_cy = y_reg;        end
        endcase
        case (jn_reg)
            2'd0:    job_last = !(|cand_reg[3:1]);
            2'd1:    job_last = !(|cand_reg[3:2]);
            2'd2:    job_last = !cand_reg[3];
            default: job_last = 1'b1;
        endcase
        q_push       = (state_reg == F_JOB) && cand_reg[jn_reg];
        q_ctrl.ebank = cur_elev_reg;
        q_ctrl.sbank = cur_score_reg;
        q_ctrl.rel   = !jn_reg[1];
        q_ctrl.top   = (q_cy == '0);
        q_ctrl.bot   = (q_cy == hm1);
        q_ctrl.last  = job_last;
    end

    // Sequencer and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cur_elev_reg  <= '0;
            cur_score_reg <= 1'b0;
            jn_reg        <= '0;
            cand_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                        state_reg <= F_S0;
                end
                F_S0: state_reg <= F_S1;
                F_S1: state_reg <= F_S2;
                F_S2: state_reg <= F_S3;
                F_S3: state_reg <= F_WR;
                F_WR:
                begin
                    cand_reg  <= cand_next;
                    jn_reg    <= '0;
                    state_reg <= F_JOB;
                end
                F_JOB:
                begin
                    jn_reg <= jn_reg + 2'd1;
                    if (jn_reg == 2'd3)
                    begin
                        state_reg <= F_IDLE;
                        if (x_reg == wm1)
                        begin
                            col_reg       <= '0;
                            row_reg       <= (y_reg == hm1) ? '0 : y_reg + 1'b1;
                            cur_elev_reg  <= (cur_elev_reg == 2'd2) ? 2'd0 : cur_elev_reg + 2'd1;
                            cur_score_reg <= !cur_score_reg;
                        end
                        else
                        begin
                            col_reg <= x_reg + 1'b1;
                            row_reg <= y_reg;
                        end
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // Pixel datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    e_reg <= clamp_unit(elevation);
                    c_reg <= clamp_unit(convexity);
                    m_reg <= clamp_unit(mountain);
                    n_reg <= {1'b0, slope_degrees, 4'b0} + 21'd32;
                    x_reg <= x_now;
                    y_reg <= y_now;
                end
            end
            F_S0:
            begin
                q0_reg  <= 15'((37'(n_reg) * 37'd64527) >> 22);
                acc_reg <= 25'(e_reg) * 25'(W_ELEV);
            end
            F_S1:
            begin
                s_reg   <= s_next;
                acc_reg <= acc_reg + 25'(c_reg) * 25'(W_CONVEX);
            end
            F_S2: acc_reg <= acc_reg + 25'(m_reg) * 25'(W_MOUNT);
            F_S3: acc_reg <= acc_reg + 25'(s_reg) * 25'(W_SLOPE);
            default: ;
        endcase
    end

endmodule

@@ src/tpk_back.sv @@
// ============================================================================
// tpk_back
// Takes one job at a time: gathers the 3x3 window, in precise mode weights
// the score, applies threshold and smoothstep, holds the result for output.
// ============================================================================
module tpk_back
    import tpk_pkg::*;
#(
    parameter int CW = 11,
    parameter int WW = 12,
    parameter int RW = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  job_ctrl_t        q_ctrl,
    input  logic [CW-1:0]    q_cx,
    input  logic [RW-1:0]    q_cy,
    input  logic             precise,
    input  logic [WW-1:0]    w_eff,
    input  logic [VAL_W-1:0] f_eff,
    output logic [1:0]       erd_bank,
    output logic [CW-1:0]    erd_col,
    input  logic [VAL_W-1:0] erd_data,
    output logic             srd_bank,
    output logic [CW-1:0]    srd_col,
    input  logic [VAL_W-1:0] srd_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [VAL_W-1:0] peak_value,
    output logic [CW-1:0]    column,
    output logic [RW-1:0]    row,
    output logic             last_of_run,
    output logic             idle
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RD   = 4'd1;
    localparam logic [3:0] B_PROM = 4'd2;
    localparam logic [3:0] B_GAIN = 4'd3;
    localparam logic [3:0] B_LOW  = 4'd4;
    localparam logic [3:0] B_LOW2 = 4'd5;
    localparam logic [3:0] B_THR  = 4'd6;
    localparam logic [3:0] B_DIV  = 4'd7;
    localparam logic [3:0] B_SQ   = 4'd8;
    localparam logic [3:0] B_CUBE = 4'd9;
    localparam logic [3:0] B_SAT  = 4'd10;
    localparam logic [3:0] B_OUT  = 4'd11;

    logic [3:0]       state_reg;
    job_ctrl_t        ctrl_reg;
    logic [CW-1:0]    cx_reg;
    logic [RW-1:0]    cy_reg;
    logic [3:0]       k_reg;
    logic [1:0]       i_reg, j_reg;
    logic             rdv_reg, rdc_reg;
    logic [VAL_W-1:0] e_reg, mx_reg, score_reg, peak_reg;
    logic [15:0]      sum_reg;
    logic [27:0]      mul_reg;
    logic [23:0]      thr_reg;
    logic [11:0]      t_reg;
    logic [12:0]      rem_reg;
    logic [23:0]      dvd_reg;
    logic [4:0]       div_cnt_reg;

    logic [1:0]       rel_row;
    logic [CW-1:0]    wm1;
    logic signed [17:0] prom;
    logic [VAL_W-1:0] prom_c;
    logic [VAL_W-1:0] gain;
    logic [VAL_W-1:0] sc_low;
    logic signed [15:0] thresh;
    logic signed [15:0] num;
    logic [13:0]      trial;
    logic             ge;
    logic [15:0]      v_sat;

    // Q0.12 product rounding
    function automatic logic [15:0] q12(input logic [27:0] p);
        return 16'((p + 28'd2048) >> 12);
    endfunction

    assign wm1   = CW'(32'(w_eff) - 32'd1);
    assign idle  = (state_reg == B_IDLE);
    assign q_pop = idle && !q_empty;

    // Window addressing with replicated edges
    always_comb
    begin
        case (i_reg)
            2'd0:    rel_row = ctrl_reg.top ? {1'b0, ctrl_reg.rel} : {1'b0, ctrl_reg.rel} + 2'd1;
            2'd1:    rel_row = {1'b0, ctrl_reg.rel};
            default: rel_row = ctrl_reg.bot ? {1'b0, ctrl_reg.rel} : {1'b0, ctrl_reg.rel} - 2'd1;
        endcase
        case (j_reg)
            2'd0:    erd_col = (cx_reg == '0) ? '0 : cx_reg - 1'b1;
            2'd1:    erd_col = cx_reg;
            default: erd_col = (32'(cx_reg) + 32'd1 < 32'(w_eff)) ? cx_reg + 1'b1 : wm1;
        endcase
        erd_bank = bank_of(ctrl_reg.ebank, rel_row);
        srd_bank = ctrl_reg.rel ? !ctrl_reg.sbank : ctrl_reg.sbank;
        srd_col  = cx_reg;
    end

    // Prominence and gain terms
    assign prom   = $signed({2'b0, e_reg, 3'b0}) + 18'sd2048 - $signed({2'b0, sum_reg});
    assign prom_c = (prom < 0) ? 13'd0 : ((prom > 18'sd4096) ? UNIT : prom[12:0]);
    assign gain   = 13'(16'd2253 + q12(mul_reg));
    assign sc_low = 13'(q12(mul_reg));

    // Threshold and smoothstep numerator
    assign thresh = 16'sd3113 - $signed(q12(28'(thr_reg)));
    assign num    = $signed({3'b0, score_reg}) - thresh + $signed({3'b0, f_eff});

    // Restoring divider step
    assign trial  = {rem_reg, dvd_reg[23]};
    assign ge     = (trial >= {1'b0, f_eff});
    assign v_sat  = q12(mul_reg);

    assign out_valid   = (state_reg == B_OUT);
    assign peak_value  = peak_reg;
    assign column      = cx_reg;
    assign row         = cy_reg;
    assign last_of_run = ctrl_reg.last;

    // Control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            rdv_reg     <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        state_reg <= B_RD;
                        k_reg     <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        rdv_reg   <= 1'b0;
                    end
                end
                B_RD:
                begin
                    rdv_reg <= (k_reg < 4'd9);
                    k_reg   <= k_reg + 4'd1;
                    if (j_reg == 2'd2)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 2'd1;
                    end
                    else
                        j_reg <= j_reg + 2'd1;
                    if (k_reg == 4'd9)
                        state_reg <= precise ? B_PROM : B_THR;
                end
                B_PROM: state_reg <= B_GAIN;
                B_GAIN: state_reg <= B_LOW;
                B_LOW:  state_reg <= B_LOW2;
                B_LOW2: state_reg <= B_THR;
                B_THR:
                begin
                    div_cnt_reg <= '0;
                    if (num <= 0 || num >= $signed({3'b0, f_eff}))
                        state_reg <= B_OUT;
                    else
                        state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd23)
                        state_reg <= B_SQ;
                end
                B_SQ:   state_reg <= B_CUBE;
                B_CUBE: state_reg <= B_SAT;
                B_SAT:  state_reg <= B_OUT;
                B_OUT:
                begin
                    if (out_ready)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        thr_reg <= 24'(f_eff) * 24'd1475;
        rdc_reg <= (i_reg == 2'd1) && (j_reg == 2'd1);
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    ctrl_reg <= q_ctrl;
                    cx_reg   <= q_cx;
                    cy_reg   <= q_cy;
                    sum_reg  <= '0;
                    mx_reg   <= '0;
                    e_reg    <= '0;
                end
            end
            B_RD:
            begin
                // Data of the address issued last cycle
                if (rdv_reg)
                begin
                    if (rdc_reg)
                        e_reg <= erd_data;
                    else
                    begin
                        sum_reg <= sum_reg + 16'(erd_data);
                        if (erd_data > mx_reg)
                            mx_reg <= erd_data;
                    end
                end
                if (k_reg == 4'd9)
                    score_reg <= srd_data;
            end
            B_PROM: mul_reg <= 28'(prom_c) * 28'd2662;
            B_GAIN: mul_reg <= 28'(score_reg) * 28'(gain);
            B_LOW:
            begin
                score_reg <= sc_low;
                mul_reg   <= 28'(sc_low) * 28'd1434;
            end
            B_LOW2:
            begin
                // Not a local high: damp the score
                if ({1'b0, e_reg} + 14'd8 < {1'b0, mx_reg})
                    score_reg <= sc_low;
            end
            B_THR:
            begin
                rem_reg <= '0;
                dvd_reg <= {num[11:0], 12'b0} + 24'(f_eff >> 1);
                if (num <= 0)
                    peak_reg <= '0;
                else
                    peak_reg <= UNIT;
            end
            B_DIV:
            begin
                rem_reg <= ge ? 13'(trial - {1'b0, f_eff}) : trial[12:0];
                dvd_reg <= {dvd_reg[22:0], ge};
            end
            B_SQ:
            begin
                t_reg   <= dvd_reg[11:0];
                mul_reg <= 28'(dvd_reg[11:0]) * 28'(dvd_reg[11:0]);
            end
            B_CUBE: mul_reg <= 28'(sc_low) * 28'(14'd12288 - {1'b0, t_reg, 1'b0});
            B_SAT:  peak_reg <= (v_sat > 16'd4096) ? UNIT : v_sat[12:0];
            default: ;
        endcase
    end

endmodule

@@ src/terrain_peak_score_3x3.sv @@
// ============================================================================
// terrain_peak_score_3x3
// Peak score over a raster terrain stream with a 3x3 elevation window.
// ============================================================================
// Pixels are taken one at a time; the next waits for an idle back end and an
// empty job queue. Each pixel releases up to four results; precise mode adds
// score weighting, and divider and smoothstep run when the score is in the band.
// Reset clears counters, bank rotation and config to defaults; line stores
// are not cleared and no entry is read before it is written.
module terrain_peak_score_3x3
    import tpk_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // elevation[15:0], convexity[31:16], mountain[47:32], slope_degrees[63:48]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // peak_value[12:0], column, row (from bit 13 up, zero padded)
    output logic [((VAL_W + $clog2(MAX_WIDTH)
                   + ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1) + 7) / 8) * 8 - 1:0]
                         m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int RW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int OUT_BITS = VAL_W + CW + RW;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
    localparam int JW       = $bits(job_ctrl_t) + CW + RW;

    logic [12:0] falloff_reg;
    logic        precise_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [VAL_W-1:0] f_eff;

    logic             back_idle, q_empty, q_full, q_push, q_pop;
    job_ctrl_t        f_ctrl, b_ctrl;
    logic [CW-1:0]    f_cx, b_cx;
    logic [RW-1:0]    f_cy, b_cy;
    logic [JW-1:0]    q_dout;

    logic             wr_en, wr_sbank, srd_bank;
    logic [1:0]       wr_ebank, erd_bank;
    logic [CW-1:0]    wr_col, erd_col, srd_col;
    logic [VAL_W-1:0] wr_elev, wr_score, erd_data, srd_data;

    logic [VAL_W-1:0] peak;
    logic [CW-1:0]    out_col;
    logic [RW-1:0]    out_row;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            falloff_reg <= 13'd1720;
            precise_reg <= 1'b0;
            width_reg   <= 12'd256;
            height_reg  <= 13'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FALLOFF: falloff_reg <= cfg_data;
                CFG_PRECISE: precise_reg <= cfg_data[0];
                CFG_WIDTH:   width_reg   <= cfg_data[11:0];
                CFG_HEIGHT:  height_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated sizes and falloff
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);

        if (falloff_reg < 13'd4)
            f_eff = 13'd4;
        else if (falloff_reg > 13'd4096)
            f_eff = UNIT;
        else
            f_eff = falloff_reg;
    end

    tpk_front #(.CW(CW), .WW(WW), .RW(RW), .HW(HW)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .elevation     (s_axis_tdata[15:0]),
        .convexity     (s_axis_tdata[31:16]),
        .mountain      (s_axis_tdata[47:32]),
        .slope_degrees (s_axis_tdata[63:48]),
        .w_eff         (w_eff),
        .h_eff         (h_eff),
        .back_idle     (back_idle),
        .q_empty       (q_empty),
        .wr_en         (wr_en),
        .wr_ebank      (wr_ebank),
        .wr_sbank      (wr_sbank),
        .wr_col        (wr_col),
        .wr_elev       (wr_elev),
        .wr_score      (wr_score),
        .q_push        (q_push),
        .q_ctrl        (f_ctrl),
        .q_cx          (f_cx),
        .q_cy          (f_cy)
    );

    tpk_queue #(.DW(JW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_ctrl, f_cx, f_cy}),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    assign {b_ctrl, b_cx, b_cy} = q_dout;

    tpk_store #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_store (
        .clk     (clk),
        .we      (wr_en),
        .w_ebank (wr_ebank),
        .w_sbank (wr_sbank),
        .w_col   (wr_col),
        .w_elev  (wr_elev),
        .w_score (wr_score),
        .r_ebank (erd_bank),
        .r_ecol  (erd_col),
        .r_edata (erd_data),
        .r_sbank (srd_bank),
        .r_scol  (srd_col),
        .r_sdata (srd_data)
    );

    tpk_back #(.CW(CW), .WW(WW), .RW(RW)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_ctrl      (b_ctrl),
        .q_cx        (b_cx),
        .q_cy        (b_cy),
        .precise     (precise_reg),
        .w_eff       (w_eff),
        .f_eff       (f_eff),
        .erd_bank    (erd_bank),
        .erd_col     (erd_col),
        .erd_data    (erd_data),
        .srd_bank    (srd_bank),
        .srd_col     (srd_col),
        .srd_data    (srd_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .peak_value  (peak),
        .column      (out_col),
        .row         (out_row),
        .last_of_run (m_axis_tlast),
        .idle        (back_idle)
    );

    assign m_axis_tdata = OUT_TW'({out_row, out_col, peak});

    // Queue never takes a job while full
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
        else $error("job queue overflow");

    // A new pixel is taken only when no job is pending or in work
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (back_idle && q_empty))
        else $error("pixel accepted while jobs pending");

    // Line stores are not written while the back end reads them
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> back_idle)
        else $error("line store written during window gather");

endmodule
